/* rtl/im2c_pkg.sv */
// Shared types and constants for the im2col patch scatter unit.
// Used by im2c_ctrl, im2c_datapath and im2col_patch_scatter_unit; no dependencies.
package im2c_pkg;

  localparam int VAL_W      = 32;
  localparam int ROW_W      = 24;
  localparam int COL_W      = 12;
  localparam int DIM_W      = 9;
  localparam int DEP_W      = 7;
  localparam int FLD_W      = 3;
  localparam int POS_W      = 8;
  localparam int CH_W       = 6;
  localparam int CNT_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int OUT_TDATA_W = 72;

  localparam logic [DIM_W-1:0] MAX_DIM      = 9'd256;
  localparam logic [DIM_W-1:0] MAX_BATCH    = 9'd256;
  localparam logic [DIM_W-1:0] MAX_CHANNELS = 9'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BATCH_COUNT   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_CHANNEL_DEPTH = 3'd3,
    REG_WINDOW_HEIGHT = 3'd4,
    REG_WINDOW_WIDTH  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC1,
    ST_CALC2,
    ST_CALC3,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic calc1;
    logic calc2;
    logic calc3;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } status_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/im2c_ctrl.sv */
// Controller state machine for the im2col patch scatter unit.
// Depends on im2c_pkg; drives commands into im2c_datapath and reads its status.
module im2c_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  input  im2c_pkg::status_t status,
  output im2c_pkg::cmd_t    cmd,
  output logic              in_ready,
  output logic              out_valid
);
  import im2c_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CALC1;
        end
      end
      ST_CALC1: begin
        state_next = status.empty ? ST_IDLE : ST_CALC2;
      end
      ST_CALC2: begin
        state_next = ST_CALC3;
      end
      ST_CALC3: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CALC1: begin
        cmd.calc1 = 1'b1;
      end
      ST_CALC2: begin
        cmd.calc2 = 1'b1;
      end
      ST_CALC3: begin
        cmd.calc3 = 1'b1;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.step  = out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/im2c_datapath.sv */
// Datapath of the im2col patch scatter unit: configuration registers, position
// counters, window bounds and destination address generation. Depends on im2c_pkg.
module im2c_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [im2c_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [im2c_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  im2c_pkg::cmd_t                      cmd,
  output im2c_pkg::status_t                   status,
  input  logic [im2c_pkg::VAL_W-1:0]          in_value,
  output logic [im2c_pkg::VAL_W-1:0]          copied_value,
  output logic [im2c_pkg::ROW_W-1:0]          dest_row,
  output logic [im2c_pkg::COL_W-1:0]          dest_col
);
  import im2c_pkg::*;

  logic [DIM_W-1:0] batch_count;
  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] image_width;
  logic [DEP_W-1:0] channel_depth;
  logic [FLD_W-1:0] window_height;
  logic [FLD_W-1:0] window_width;

  logic [DIM_W-1:0] nb;
  logic [DIM_W-1:0] h;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] d_full;
  logic [DEP_W-1:0] d;

  logic [POS_W-1:0] cur_batch;
  logic [POS_W-1:0] cur_row;
  logic [POS_W-1:0] cur_col;
  logic [CH_W-1:0]  cur_chan;

  logic [POS_W-1:0] b_l;
  logic [POS_W-1:0] r_l;
  logic [POS_W-1:0] c_l;
  logic [CH_W-1:0]  ch_l;
  logic [VAL_W-1:0] value;

  logic [DIM_W-1:0] across;
  logic [CNT_W-1:0] count;
  logic [POS_W-1:0] ylo;
  logic [POS_W-1:0] yhi;
  logic [POS_W-1:0] xlo;
  logic [POS_W-1:0] xhi;
  logic [DIM_W-1:0] fwd;

  logic [ROW_W-1:0] prod_b;
  logic [CNT_W-1:0] ymul;
  logic [CH_W-1:0]  off;

  logic [POS_W-1:0] wy;
  logic [POS_W-1:0] wx;
  logic [ROW_W-1:0] row_line;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] col_line;
  logic [COL_W-1:0] col_cur;

  logic [DIM_W-1:0]   across_n;
  logic [DIM_W-1:0]   hspan_n;
  logic [DIM_W-1:0]   hlim;
  logic [DIM_W-1:0]   wlim;
  logic [2*DIM_W-1:0] count_full;
  logic [DIM_W-1:0]   r_inc;
  logic [DIM_W-1:0]   c_inc;
  logic [POS_W-1:0]   ylo_n;
  logic [POS_W-1:0]   yhi_n;
  logic [POS_W-1:0]   xlo_n;
  logic [POS_W-1:0]   xhi_n;
  logic [9:0]         fwd_full;
  logic               win_ok;
  logic [24:0]        prod_full;
  logic [16:0]        ymul_full;
  logic [POS_W-1:0]   dy;
  logic [POS_W-1:0]   dx;
  logic [6:0]         off_sum;
  logic [12:0]        offd_full;

  logic [CH_W-1:0]  chan_inc;
  logic [POS_W-1:0] col_inc;
  logic [POS_W-1:0] row_inc;
  logic [POS_W-1:0] batch_inc;

  assign nb     = clamp_dim(batch_count, MAX_BATCH);
  assign h      = clamp_dim(image_height, MAX_DIM);
  assign w      = clamp_dim(image_width, MAX_DIM);
  assign d_full = clamp_dim({2'b00, channel_depth}, MAX_CHANNELS);
  assign d      = d_full[DEP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count   <= DIM_W'(1);
      image_height  <= DIM_W'(32);
      image_width   <= DIM_W'(32);
      channel_depth <= DEP_W'(3);
      window_height <= FLD_W'(3);
      window_width  <= FLD_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BATCH_COUNT:   batch_count   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_CHANNEL_DEPTH: channel_depth <= cfg_data[DEP_W-1:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[FLD_W-1:0];
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[FLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Each counter wraps at its limit or when its masked increment rolls over.
  assign chan_inc  = cur_chan + CH_W'(1);
  assign col_inc   = cur_col + POS_W'(1);
  assign row_inc   = cur_row + POS_W'(1);
  assign batch_inc = cur_batch + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_batch <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      cur_chan  <= '0;
    end else if (cmd.load) begin
      if ({1'b0, chan_inc} >= d || chan_inc == '0) begin
        cur_chan <= '0;
        if ({1'b0, col_inc} >= w || col_inc == '0) begin
          cur_col <= '0;
          if ({1'b0, row_inc} >= h || row_inc == '0) begin
            cur_row <= '0;
            cur_batch <= ({1'b0, batch_inc} >= nb) ? '0 : batch_inc;
          end else begin
            cur_row <= row_inc;
          end
        end else begin
          cur_col <= col_inc;
        end
      end else begin
        cur_chan <= chan_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_l   <= cur_batch;
      r_l   <= cur_row;
      c_l   <= cur_col;
      ch_l  <= cur_chan;
      value <= in_value;
    end
  end

  // Window bounds for the latched position.
  assign across_n   = w - {6'b0, window_width} + DIM_W'(1);
  assign hspan_n    = h - {6'b0, window_height} + DIM_W'(1);
  assign hlim       = h - {6'b0, window_height};
  assign wlim       = w - {6'b0, window_width};
  assign count_full = {{DIM_W{1'b0}}, across_n} * {{DIM_W{1'b0}}, hspan_n};
  assign r_inc      = {1'b0, r_l} + DIM_W'(1);
  assign c_inc      = {1'b0, c_l} + DIM_W'(1);
  assign ylo_n      = (r_inc > {6'b0, window_height}) ?
                      POS_W'(r_inc - {6'b0, window_height}) : '0;
  assign yhi_n      = ({1'b0, r_l} < hlim) ? r_l : hlim[POS_W-1:0];
  assign xlo_n      = (c_inc > {6'b0, window_width}) ?
                      POS_W'(c_inc - {6'b0, window_width}) : '0;
  assign xhi_n      = ({1'b0, c_l} < wlim) ? c_l : wlim[POS_W-1:0];
  assign fwd_full   = {7'b0, window_width} * {3'b0, d};
  assign win_ok     = window_height[0] && window_width[0] &&
                      ({6'b0, window_height} <= h) && ({6'b0, window_width} <= w);

  assign status.empty = !win_ok || ({1'b0, r_l} >= h) || ({1'b0, c_l} >= w);
  assign status.last  = (wy == yhi) && (wx == xhi);

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      across <= across_n;
      count  <= count_full[CNT_W-1:0];
      ylo    <= ylo_n;
      yhi    <= yhi_n;
      xlo    <= xlo_n;
      xhi    <= xhi_n;
      fwd    <= fwd_full[DIM_W-1:0];
    end
  end

  assign prod_full = {17'b0, b_l} * {8'b0, count};
  assign ymul_full = {9'b0, ylo} * {8'b0, across};
  assign dy        = r_l - ylo;
  assign dx        = c_l - xlo;
  assign off_sum   = {1'b0, {3'b0, dy[2:0]} * {3'b0, window_width}} + {4'b0, dx[2:0]};

  always_ff @(posedge clk) begin
    if (cmd.calc2) begin
      prod_b <= prod_full[ROW_W-1:0];
      ymul   <= ymul_full[CNT_W-1:0];
      off    <= off_sum[CH_W-1:0];
    end
  end

  assign offd_full = {7'b0, off} * {6'b0, d};

  always_ff @(posedge clk) begin
    if (cmd.calc3) begin
      wy       <= ylo;
      wx       <= xlo;
      row_line <= prod_b + {7'b0, ymul} + {16'b0, xlo};
      row_cur  <= prod_b + {7'b0, ymul} + {16'b0, xlo};
      col_line <= offd_full[COL_W-1:0] + {6'b0, ch_l};
      col_cur  <= offd_full[COL_W-1:0] + {6'b0, ch_l};
    end else if (cmd.step && !status.last) begin
      if (wx == xhi) begin
        wx       <= xlo;
        wy       <= wy + POS_W'(1);
        row_line <= row_line + {15'b0, across};
        row_cur  <= row_line + {15'b0, across};
        col_line <= col_line - {3'b0, fwd};
        col_cur  <= col_line - {3'b0, fwd};
      end else begin
        wx      <= wx + POS_W'(1);
        row_cur <= row_cur + ROW_W'(1);
        col_cur <= col_cur - {5'b0, d};
      end
    end
  end

  assign copied_value = value;
  assign dest_row     = row_cur;
  assign dest_col     = col_cur;

endmodule

/* rtl/im2col_patch_scatter_unit.sv */
// Usage: a tensor enters on the s_axis channel one element per beat, in batch,
// row, column, channel order. For each element the unit sends one beat on the
// m_axis channel for every unpadded receptive-field window that holds it,
// carrying the element bits, the im2col matrix row and column, in ascending
// row order; tlast marks the final beat for that element. An element that
// lies in no window (even or oversized field, or position past the image)
// produces no beats.
// Timing: an element is taken when the unit is idle; after the setup states CALC1,
// CALC2 and CALC3 the first result is shown, then one result per cycle while
// m_tready is high. A single address generator walks the windows.
// Reset: rst (synchronous) loads the register defaults 1, 32, 32, 3, 3, 3 and
// clears the position counters. The user writes registers through cfg_we,
// cfg_index and cfg_data only while the unit is idle; it does not enforce this.
// Stall: a held m_tready keeps the current result stable and pauses the walk;
// s_tready stays low until the last result of the element is taken.
module im2col_patch_scatter_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [im2c_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [im2c_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [im2c_pkg::VAL_W-1:0]          s_tdata,   // element_value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // copied_value [31:0], dest_row [55:32], dest_col [67:56], zero pad [71:68]
  output logic [im2c_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast    // last_copy
);
  import im2c_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [VAL_W-1:0] copied_value;
  logic [ROW_W-1:0] dest_row;
  logic [COL_W-1:0] dest_col;

  im2c_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  im2c_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .in_value     (s_tdata),
    .copied_value (copied_value),
    .dest_row     (dest_row),
    .dest_col     (dest_col)
  );

  assign m_tdata = {4'b0, dest_col, dest_row, copied_value};
  assign m_tlast = status.last;

endmodule
